>>> hdl/rotor_byte_cipher_unit_defines.svh
// assertion helpers used by the cipher top module
`ifndef ROTOR_BYTE_CIPHER_UNIT_DEFINES_SVH
`define ROTOR_BYTE_CIPHER_UNIT_DEFINES_SVH

// property checked on every rising clk edge outside reset
`define RBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RBC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/rbc_pkg.sv
package rbc_pkg;

    localparam int WHEELS_DEFAULT = 16;

    localparam logic [2:0] CMD_LOAD_WHEEL = 3'd0;
    localparam logic [2:0] CMD_LOAD_PLUG  = 3'd1;
    localparam logic [2:0] CMD_LOAD_REFL  = 3'd2;
    localparam logic [2:0] CMD_ZERO_POS   = 3'd3;
    localparam logic [2:0] CMD_CIPHER     = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    // broadcast control from the top to every wheel cell
    typedef struct packed {
        logic       wheel_load;
        logic       zero_pos;
        logic [3:0] wheel_index;
        logic [7:0] table_position;
        logic [7:0] table_value;
    } rbc_ctl_t;

    // byte moving between neighboring cells
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       carry;
    } rbc_tok_t;

endpackage

>>> hdl/rbc_cell.sv
module rbc_cell #(
    parameter int IDX    = 0,
    parameter int WHEELS = 16,
    parameter int NW     = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rbc_pkg::rbc_ctl_t ctl,
    input  logic [NW-1:0]     active_count,
    input  rbc_pkg::rbc_tok_t fwd_in,
    output rbc_pkg::rbc_tok_t fwd_out,
    input  rbc_pkg::rbc_tok_t bwd_in,
    output rbc_pkg::rbc_tok_t bwd_out
);
    import rbc_pkg::*;

    logic [7:0] fwd_mem [256];
    logic [7:0] inv_mem [256];

    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic       fw_v_reg;
    logic [7:0] fw_rd_reg;
    logic [7:0] fw_byp_reg;
    logic       bw_v_reg;
    logic       bw_c_reg;
    logic [7:0] bw_rd_reg;
    logic [7:0] bw_byp_reg;
    logic [7:0] bw_pos_reg;

    logic       active;
    logic       sel;
    logic [7:0] fw_addr;
    logic [7:0] bw_addr;
    logic       carry_out;

    assign active  = (IDX < int'(active_count));
    assign sel     = ctl.wheel_load && (int'(ctl.wheel_index) == IDX);
    assign fw_addr = fwd_in.data + pos_reg;
    assign bw_addr = bwd_in.data + pos_reg;

    // inactive cells just forward the carry toward wheel 0
    assign carry_out = active ? (bwd_in.carry && (pos_reg == 8'hFF)) : bwd_in.carry;

    always_comb
    begin
        pos_next = pos_reg;
        if (ctl.zero_pos)
        begin
            pos_next = 8'd0;
        end
        else if (bwd_in.valid && active && bwd_in.carry)
        begin
            pos_next = pos_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 8'd0;
            fw_v_reg <= 1'b0;
            bw_v_reg <= 1'b0;
            bw_c_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fw_v_reg <= fwd_in.valid;
            bw_v_reg <= bwd_in.valid;
            bw_c_reg <= bwd_in.valid && carry_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            fwd_mem[ctl.table_position] <= ctl.table_value;
            inv_mem[ctl.table_value]    <= ctl.table_position;
        end
        if (fwd_in.valid)
        begin
            fw_rd_reg  <= fwd_mem[fw_addr];
            fw_byp_reg <= fwd_in.data;
        end
        if (bwd_in.valid)
        begin
            bw_rd_reg  <= inv_mem[bw_addr];
            bw_byp_reg <= bwd_in.data;
            bw_pos_reg <= pos_reg;
        end
    end

    // position is stable between the forward read and its subtract
    assign fwd_out.valid = fw_v_reg;
    assign fwd_out.data  = active ? (fw_rd_reg - pos_reg) : fw_byp_reg;
    assign fwd_out.carry = 1'b0;

    assign bwd_out.valid = bw_v_reg;
    assign bwd_out.data  = active ? (bw_rd_reg - bw_pos_reg) : bw_byp_reg;
    assign bwd_out.carry = bw_c_reg;

endmodule

>>> hdl/rotor_byte_cipher_unit.sv
// cipher command: the result passes through one registered table read per wheel
// cell each way plus plugboard and reflector reads; the next transfer is taken
// once the backward pass is done and the result register is free or being read,
// load and zero commands are taken without entering the busy state
// reset clears positions and wheel_count to 1, tables are undefined until loaded
`include "rotor_byte_cipher_unit_defines.svh"

module rotor_byte_cipher_unit #(
    parameter int WHEELS = rbc_pkg::WHEELS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [3:0] wheel_index,
    input  logic [7:0] table_position,
    input  logic [7:0] table_value,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cipher_byte
);
    import rbc_pkg::*;

    localparam int NW = $clog2(WHEELS + 1);

    logic [7:0] plug_fwd_mem [256];
    logic [7:0] plug_inv_mem [256];
    logic [7:0] refl_mem     [256];

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] wheel_count_reg;
    logic       pf_v_reg;
    logic [7:0] pf_rd_reg;
    logic       rf_v_reg;
    logic [7:0] rf_rd_reg;
    logic       out_valid_reg;
    logic [7:0] pi_rd_reg;

    logic          accept;
    logic          start;
    logic          bw_done;
    logic [NW-1:0] active_count;
    rbc_ctl_t      ctl;
    rbc_tok_t      fw [WHEELS+1];
    rbc_tok_t      bw [WHEELS+1];

    assign accept  = in_valid && in_ready;
    assign bw_done = bw[0].valid;

    always_comb
    begin
        ctl.wheel_load     = 1'b0;
        ctl.zero_pos       = 1'b0;
        ctl.wheel_index    = wheel_index;
        ctl.table_position = table_position;
        ctl.table_value    = table_value;
        start              = 1'b0;
        unique case (command)
            CMD_LOAD_WHEEL: ctl.wheel_load = accept;
            CMD_ZERO_POS:   ctl.zero_pos   = accept;
            CMD_CIPHER:     start          = accept;
            default:        ;
        endcase
    end

    always_comb
    begin
        if (wheel_count_reg == 5'd0)
        begin
            active_count = NW'(1);
        end
        else if (int'(wheel_count_reg) > WHEELS)
        begin
            active_count = NW'(WHEELS);
        end
        else
        begin
            active_count = NW'(wheel_count_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start)   state_next = ST_BUSY;
            ST_BUSY: if (bw_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: in_ready = !out_valid_reg || out_ready;
            ST_BUSY: in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wheel_count_reg <= 5'd1;
            pf_v_reg        <= 1'b0;
            rf_v_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                wheel_count_reg <= cfg_wdata;
            end
            pf_v_reg <= start;
            rf_v_reg <= fw[WHEELS].valid;
            if (bw_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (command == CMD_LOAD_PLUG))
        begin
            plug_fwd_mem[table_position] <= table_value;
            plug_inv_mem[table_value]    <= table_position;
        end
        if (accept && (command == CMD_LOAD_REFL))
        begin
            refl_mem[table_position] <= table_value;
        end
        if (start)
        begin
            pf_rd_reg <= plug_fwd_mem[data_byte];
        end
        if (fw[WHEELS].valid)
        begin
            rf_rd_reg <= refl_mem[fw[WHEELS].data];
        end
        if (bw_done)
        begin
            pi_rd_reg <= plug_inv_mem[bw[0].data];
        end
    end

    assign fw[0].valid      = pf_v_reg;
    assign fw[0].data       = pf_rd_reg;
    assign fw[0].carry      = 1'b0;
    // the odometer step rides on the backward transfer, entering at the last cell
    assign bw[WHEELS].valid = rf_v_reg;
    assign bw[WHEELS].data  = rf_rd_reg;
    assign bw[WHEELS].carry = 1'b1;

    for (genvar i = 0; i < WHEELS; i++)
    begin : g_cell
        rbc_cell #(
            .IDX    (i),
            .WHEELS (WHEELS),
            .NW     (NW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .active_count (active_count),
            .fwd_in       (fw[i]),
            .fwd_out      (fw[i+1]),
            .bwd_in       (bw[i+1]),
            .bwd_out      (bw[i])
        );
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = pi_rd_reg;

    `RBC_NEVER(a_ready_busy, (state_reg == ST_BUSY) && in_ready, "input ready while busy")
    `RBC_ASSERT(a_out_rise, $rose(out_valid_reg) |-> $past(bw_done), "result without backward pass")
    `RBC_ASSERT(a_one_token, $onehot0({pf_v_reg, rf_v_reg, bw_done}), "more than one byte in flight")
    `RBC_ASSERT(a_done_busy, bw_done |-> (state_reg == ST_BUSY), "backward pass ended while idle")

endmodule

>>> sim/rbc_checker.sv
module rbc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] command,
    input  logic [3:0] wheel_index,
    input  logic [7:0] table_position,
    input  logic [7:0] table_value,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] cipher_byte,
    input  logic       end_check,
    output int         errors,
    output int         pending,
    output int         bytes_checked
);
    import rbc_pkg::*;

    localparam int NUM_WHEELS = WHEELS_DEFAULT;

    logic [7:0] wheel_fwd [NUM_WHEELS][256];
    logic [7:0] wheel_inv [NUM_WHEELS][256];
    logic [7:0] plug_fwd [256];
    logic [7:0] plug_inv [256];
    logic [7:0] reflector [256];
    logic [7:0] rotor_pos [NUM_WHEELS];
    logic [4:0] wheel_count_reg;
    logic [7:0] expected_bytes [$];
    logic       end_seen;

    initial
    begin
        errors = 0;
        bytes_checked = 0;
        end_seen = 1'b0;
    end

    assign pending = expected_bytes.size();

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s (expected %0d, got %0d)", $realtime, what, want, got);
        errors++;
    endtask

    function automatic int active_wheels();
        int k;
        k = wheel_count_reg;
        if (k < 1)
            k = 1;
        if (k > NUM_WHEELS)
            k = NUM_WHEELS;
        return k;
    endfunction

    // plugboard, wheels forward, reflector, wheels back, plugboard back,
    // then step the positions like an odometer
    task automatic encipher_byte(input logic [7:0] plain);
        logic [7:0] c;
        int n;
        c = plug_fwd[plain];
        n = active_wheels();
        for (int w = 0; w < n; w++)
            c = wheel_fwd[w][8'(c + rotor_pos[w])] - rotor_pos[w];
        c = reflector[c];
        for (int w = n - 1; w >= 0; w--)
            c = wheel_inv[w][8'(c + rotor_pos[w])] - rotor_pos[w];
        c = plug_inv[c];
        expected_bytes.push_back(c);
        for (int w = n - 1; w >= 0; w--)
        begin
            rotor_pos[w] = rotor_pos[w] + 8'd1;
            if (rotor_pos[w] != 8'd0)
                break;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
                rotor_pos[w] = 8'd0;
            wheel_count_reg = 5'd1;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_we)
                wheel_count_reg = cfg_wdata;
            if (in_valid && in_ready)
            begin
                case (command)
                    CMD_LOAD_WHEEL:
                    begin
                        wheel_fwd[wheel_index][table_position] = table_value;
                        wheel_inv[wheel_index][table_value] = table_position;
                    end
                    CMD_LOAD_PLUG:
                    begin
                        plug_fwd[table_position] = table_value;
                        plug_inv[table_value] = table_position;
                    end
                    CMD_LOAD_REFL:
                        reflector[table_position] = table_value;
                    CMD_ZERO_POS:
                        for (int w = 0; w < NUM_WHEELS; w++)
                            rotor_pos[w] = 8'd0;
                    CMD_CIPHER:
                        encipher_byte(data_byte);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("result transfer with nothing expected", -1, cipher_byte);
                else
                begin
                    if (cipher_byte !== expected_bytes[0])
                        report_mismatch("cipher_byte", expected_bytes[0], cipher_byte);
                    void'(expected_bytes.pop_front());
                    bytes_checked++;
                end
            end
            if (end_check && !end_seen)
            begin
                end_seen = 1'b1;
                if (expected_bytes.size() != 0)
                    report_mismatch("results still outstanding at end", 0,
                                    expected_bytes.size());
            end
        end
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    import rbc_pkg::*;

    localparam int NUM_WHEELS = WHEELS_DEFAULT;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
    localparam int DRAIN_CYCLES = 2 * NUM_WHEELS + 10;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] command;
    logic [3:0] wheel_index;
    logic [7:0] table_position;
    logic [7:0] table_value;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] cipher_byte;
    logic       end_check;
    int         errors;
    int         pending;
    int         bytes_checked;

    // shadow of the loaded tables, used to keep later loads well formed
    logic [7:0] wheel_shadow [NUM_WHEELS][256];
    logic [7:0] plug_shadow [256];
    logic [7:0] refl_shadow [256];

    logic       send_gaps;
    logic       recv_gaps;
    logic       long_hold_req;
    int         sent_items;
    int         sent_ciphers;

    rotor_byte_cipher_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .wheel_index    (wheel_index),
        .table_position (table_position),
        .table_value    (table_value),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cipher_byte    (cipher_byte)
    );

    rbc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .wheel_index    (wheel_index),
        .table_position (table_position),
        .table_value    (table_value),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cipher_byte    (cipher_byte),
        .end_check      (end_check),
        .errors         (errors),
        .pending        (pending),
        .bytes_checked  (bytes_checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #(20 * 3_000_000);
        $display("timeout waiting for the cipher unit");
        $display("** rotor_byte_cipher_unit: FAILED **");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int hold;
        out_ready = 1'b1;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && hold == 0)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < 400; i++)
                    @(negedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    out_ready <= 1'b1;
            end
            else if (recv_gaps && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 18);
                out_ready <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(input logic [2:0] cmd, input logic [3:0] widx,
                             input logic [7:0] pos, input logic [7:0] val,
                             input logic [7:0] plain);
        int gap;
        gap = 0;
        if (send_gaps && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        wheel_index <= widx;
        table_position <= pos;
        table_value <= val;
        data_byte <= plain;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent_items++;
        if (cmd == CMD_CIPHER)
            sent_ciphers++;
    endtask

    task automatic load_wheel(input logic [3:0] w, input logic [7:0] a, input logic [7:0] v);
        wheel_shadow[w][a] = v;
        send_item(CMD_LOAD_WHEEL, w, a, v, 8'($urandom));
    endtask

    task automatic load_plug(input logic [7:0] a, input logic [7:0] v);
        plug_shadow[a] = v;
        send_item(CMD_LOAD_PLUG, 4'($urandom), a, v, 8'($urandom));
    endtask

    task automatic load_refl(input logic [7:0] a, input logic [7:0] v);
        refl_shadow[a] = v;
        send_item(CMD_LOAD_REFL, 4'($urandom), a, v, 8'($urandom));
    endtask

    task automatic encipher(input logic [7:0] plain);
        send_item(CMD_CIPHER, 4'($urandom), 8'($urandom), 8'($urandom), plain);
    endtask

    task automatic shuffle_bytes(output logic [7:0] perm [256]);
        int j;
        logic [7:0] t;
        for (int i = 0; i < 256; i++)
            perm[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_wheel_count(input logic [4:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // well-formed table edits keep every table a permutation and the
    // reflector an involution; plain stray loads are mixed in as noise
    task automatic random_item();
        int pick;
        logic [3:0] w;
        logic [7:0] a, b, ra, rb, va, vb;
        pick = $urandom_range(0, 99);
        a = 8'($urandom);
        b = 8'($urandom);
        w = 4'($urandom);
        if (pick < 70)
            encipher(8'($urandom));
        else if (pick < 80)
        begin
            va = wheel_shadow[w][a];
            vb = wheel_shadow[w][b];
            load_wheel(w, a, vb);
            load_wheel(w, b, va);
        end
        else if (pick < 85)
        begin
            va = plug_shadow[a];
            vb = plug_shadow[b];
            load_plug(a, vb);
            load_plug(b, va);
        end
        else if (pick < 90)
        begin
            ra = refl_shadow[a];
            rb = refl_shadow[b];
            if (a != b && a != rb && ra != b && ra != rb && a != ra && b != rb)
            begin
                load_refl(a, b);
                load_refl(b, a);
                load_refl(ra, rb);
                load_refl(rb, ra);
            end
            else
                encipher(8'($urandom));
        end
        else if (pick < 94)
        begin
            case ($urandom_range(0, 2))
                0: load_wheel(w, a, b);
                1: load_plug(a, b);
                default: load_refl(a, b);
            endcase
        end
        else if (pick < 97)
            send_item(CMD_ZERO_POS, w, a, b, 8'($urandom));
        else
            send_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), w, a, b,
                      8'($urandom));
    endtask

    initial
    begin
        logic [7:0] perm [256];
        logic [4:0] phase_counts [8];
        int phase_items [8];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 5'd0;
        in_valid = 1'b0;
        command = CMD_ZERO_POS;
        wheel_index = 4'd0;
        table_position = 8'd0;
        table_value = 8'd0;
        data_byte = 8'd0;
        end_check = 1'b0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        long_hold_req = 1'b0;
        sent_items = 0;
        sent_ciphers = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full key load: every entry written before any cipher transfer
        shuffle_bytes(perm);
        for (int i = 0; i < 256; i++)
            load_plug(8'(i), perm[i]);
        shuffle_bytes(perm);
        for (int i = 0; i < 256; i += 2)
        begin
            load_refl(perm[i], perm[i + 1]);
            load_refl(perm[i + 1], perm[i]);
        end
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            shuffle_bytes(perm);
            for (int i = 0; i < 256; i++)
                load_wheel(4'(w), 8'(i), perm[i]);
        end

        // directed: field extremes, every command, default wheel count
        encipher(8'h00);
        encipher(8'hff);
        send_item(CMD_ZERO_POS, 4'hf, 8'hff, 8'hff, 8'hff);
        encipher(8'h00);
        send_item(CMD_SPARE_FIRST, 4'hf, 8'hff, 8'hff, 8'hff);
        send_item(3'd6, 4'h0, 8'h00, 8'h00, 8'h00);
        send_item(CMD_SPARE_LAST, 4'ha, 8'h55, 8'haa, 8'h5a);
        load_wheel(4'hf, 8'hff, wheel_shadow[15][0]);
        load_wheel(4'hf, 8'h00, wheel_shadow[15][255]);
        load_wheel(4'h0, 8'h00, wheel_shadow[0][0]);
        load_plug(8'hff, plug_shadow[255]);
        load_refl(8'h00, refl_shadow[0]);
        encipher(8'h80);
        encipher(8'h7f);
        // a stray reflector write leaves it non-involutive
        load_refl(8'h01, refl_shadow[0]);
        encipher(8'h01);
        load_refl(8'h01, refl_shadow[refl_shadow[1]] == 8'h01 ? refl_shadow[1] : 8'h00);
        encipher(8'hc3);
        encipher(8'h3c);

        // the receiver stalls for long while ciphers keep coming
        long_hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            encipher(8'($urandom));
        wait_idle();

        phase_counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd3};
        phase_items = '{220, 330, 200, 220, 200, 160, 200, 200};
        foreach (phase_counts[p])
        begin
            write_wheel_count(p == 7 ? 5'($urandom) : phase_counts[p]);
            if (p == 7)
            begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            send_item(CMD_ZERO_POS, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            // one wheel: enough ciphers in a row for wheel 0 to wrap
            if (phase_counts[p] == 5'd1)
                for (int i = 0; i < 260; i++)
                    encipher(8'($urandom));
            for (int i = 0; i < phase_items[p]; i++)
                random_item();
            wait_idle();
        end

        end_check = 1'b1;
        @(negedge clk);
        @(negedge clk);
        $display("covered %0d transfers in, %0d ciphers, %0d results checked",
                 sent_items, sent_ciphers, bytes_checked);
        $display("wheel counts 0, 1, 2, 3 or random, 5, 16, 17, 31; full key reloads and edits");
        if (errors == 0)
            $display("** rotor_byte_cipher_unit: PASSED **");
        else
            $display("** rotor_byte_cipher_unit: FAILED **");
        $finish;
    end

endmodule
